### hdl/esub_pkg.sv
`default_nettype none

package esub_pkg;

    // default sizes
    localparam int DEF_SLOTS   = 8;
    localparam int DEF_SENSORS = 4;
    localparam int DEF_SIGNALS = 8;

    // fixed field widths
    localparam int SIG_W    = 3;
    localparam int SEN_W    = 2;
    localparam int STATUS_W = 2;
    localparam int ADDED_W  = 3;
    localparam int WAKE_W   = 8;
    localparam int BITS_W   = 4;

    // stream widths
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;

    // received bytes that move a sensor
    localparam logic [7:0] BYTE_S1_LOW  = 8'h61;
    localparam logic [7:0] BYTE_S1_HIGH = 8'h62;
    localparam logic [7:0] BYTE_S2_LOW  = 8'h63;
    localparam logic [7:0] BYTE_S2_HIGH = 8'h64;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE  = 2'd0,
        ST_ADDED = 2'd1,
        ST_DUP   = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [SIG_W-1:0] signal;
        logic [SEN_W-1:0] sensor;
        logic             level;
    } slot_entry_t;

    // status of the registered slot read
    typedef struct packed {
        logic vld;
        logic occupied;
    } rd_status_t;

    // result of the shared compare unit
    typedef struct packed {
        logic dup;
        logic fire;
    } match_t;

endpackage

`default_nettype wire

### hdl/esub_slot_mem.sv
`default_nettype none

module esub_slot_mem #(
    parameter int SLOTS = esub_pkg::DEF_SLOTS
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            rd_en,
    input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]      rd_addr,
    output esub_pkg::slot_entry_t                                rd_data,
    output esub_pkg::rd_status_t                                 rd_st,
    output logic      [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]      rd_idx,
    input  wire logic                                            wr_en,
    input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]      wr_addr,
    input  esub_pkg::slot_entry_t                                wr_data,
    input  wire logic                                            clr_en,
    input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]      clr_addr
);
    import esub_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    slot_entry_t      mem [SLOTS];
    logic [SLOTS-1:0] occ_reg;
    logic             rd_vld_reg;
    logic             rd_occ_reg;
    logic [IW-1:0]    rd_idx_reg;
    slot_entry_t      rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    // occupancy flags, cleared at reset so the memory needs no sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            rd_vld_reg <= 1'b0;
            rd_occ_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
            if (rd_en)
            begin
                rd_occ_reg <= occ_reg[rd_addr];
            end
            if (wr_en)
            begin
                occ_reg[wr_addr] <= 1'b1;
            end
            if (clr_en)
            begin
                occ_reg[clr_addr] <= 1'b0;
            end
        end
    end

    assign rd_data     = rd_data_reg;
    assign rd_idx      = rd_idx_reg;
    assign rd_st.vld      = rd_vld_reg;
    assign rd_st.occupied = rd_occ_reg;

endmodule

`default_nettype wire

### hdl/esub_match.sv
`default_nettype none

module esub_match (
    input  esub_pkg::slot_entry_t                entry,
    input  wire logic                            occupied,
    input  esub_pkg::slot_entry_t                req,
    input  wire logic [esub_pkg::BITS_W-1:0]     sensor_bits,
    output esub_pkg::match_t                     result
);
    import esub_pkg::*;

    // exact match against an occupied slot
    assign result.dup  = occupied && (entry == req);
    // slot fires when its sensor has moved away from the stored level
    assign result.fire = occupied && (sensor_bits[entry.sensor] != entry.level);

endmodule

`default_nettype wire

### hdl/event_subscription_table.sv
// channel  | group            | contents
// ---------+------------------+---------------------------------------------------------
// tick in  | s_tvalid/tready  | s_tdata: request_signal, request_sensor, request_level,
//          |                  |          rx_byte; s_tuser: has_request, has_byte
// result   | m_tvalid/tready  | m_tdata: request_status, added_slot, wake_mask,
//          |                  |          sensor_bits
//
// from transfer to result a tick goes through these steps (the first is skipped without
// a valid request): one scan of the slot memory for duplicate and free slot, one update
// step, one scan for firing slots, and the load of the result register.
// both scans read one slot a cycle through the single registered read port.
// s_tready is high only while idle; a result waiting on m_tready holds the next
// tick in its final cycle. reset clears the occupancy flags and sensors at once.
`default_nettype none

module event_subscription_table #(
    parameter int SLOTS   = esub_pkg::DEF_SLOTS,
    parameter int SENSORS = esub_pkg::DEF_SENSORS,
    parameter int SIGNALS = esub_pkg::DEF_SIGNALS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // request_signal[2:0], request_sensor[4:3], request_level[5], rx_byte[13:6]
    input  wire logic [esub_pkg::S_DATA_W-1:0]     s_tdata,
    // has_request[0], has_byte[1]
    input  wire logic [esub_pkg::S_USER_W-1:0]     s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // request_status[1:0], added_slot[4:2], wake_mask[12:5], sensor_bits[16:13]
    output logic      [esub_pkg::M_DATA_W-1:0]     m_tdata
);
    import esub_pkg::*;

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IW-1:0]    LAST_IDX  = IW'(SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSCAN,
        S_DECIDE,
        S_WSCAN,
        S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      issue_reg, issue_next;
    slot_entry_t           req_reg, req_next;
    logic                  req_ok_reg, req_ok_next;
    logic                  has_byte_reg, has_byte_next;
    logic [7:0]            rx_byte_reg, rx_byte_next;
    logic                  dup_reg, dup_next;
    logic                  free_found_reg, free_found_next;
    logic [IW-1:0]         free_idx_reg, free_idx_next;
    logic [WAKE_W-1:0]     wake_reg, wake_next;
    status_t               status_reg, status_next;
    logic [BITS_W-1:0]     sensor_reg, sensor_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    slot_entry_t           in_entry;
    logic                  in_req_ok;
    logic                  rd_en;
    logic                  wr_en;
    logic                  clr_en;
    slot_entry_t           rd_data;
    rd_status_t            rd_st;
    logic [IW-1:0]         rd_idx;
    match_t                mt;
    logic [ADDED_W-1:0]    added;

    assign in_entry.signal = s_tdata[2:0];
    assign in_entry.sensor = s_tdata[4:3];
    assign in_entry.level  = s_tdata[5];

    assign in_req_ok = s_tuser[0] && (in_entry.signal != '0)
                       && (32'(in_entry.signal) < 32'(SIGNALS))
                       && (32'(in_entry.sensor) < 32'(SENSORS));

    esub_slot_mem #(
        .SLOTS(SLOTS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (issue_reg[IW-1:0]),
        .rd_data  (rd_data),
        .rd_st    (rd_st),
        .rd_idx   (rd_idx),
        .wr_en    (wr_en),
        .wr_addr  (free_idx_reg),
        .wr_data  (req_reg),
        .clr_en   (clr_en),
        .clr_addr (rd_idx)
    );

    esub_match u_match (
        .entry       (rd_data),
        .occupied    (rd_st.occupied),
        .req         (req_reg),
        .sensor_bits (sensor_reg),
        .result      (mt)
    );

    assign added = (status_reg == ST_ADDED) ? ADDED_W'(free_idx_reg) : '0;

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        req_next        = req_reg;
        req_ok_next     = req_ok_reg;
        has_byte_next   = has_byte_reg;
        rx_byte_next    = rx_byte_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        wake_next       = wake_reg;
        status_next     = status_reg;
        sensor_next     = sensor_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        clr_en          = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next        = in_entry;
                    req_ok_next     = in_req_ok;
                    has_byte_next   = s_tuser[1];
                    rx_byte_next    = s_tdata[13:6];
                    dup_next        = 1'b0;
                    free_found_next = 1'b0;
                    wake_next       = '0;
                    issue_next      = '0;
                    state_next      = in_req_ok ? S_DSCAN : S_DECIDE;
                end
            end
            S_DSCAN:
            begin
                if (issue_reg < SLOTS_CNT)
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                if (rd_st.vld)
                begin
                    if (mt.dup)
                    begin
                        dup_next = 1'b1;
                    end
                    // lowest free slot is the first one seen
                    if (!rd_st.occupied && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx;
                    end
                    if (rd_idx == LAST_IDX)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                priority if (!req_ok_reg)
                begin
                    status_next = ST_NONE;
                end
                else if (dup_reg)
                begin
                    status_next = ST_DUP;
                end
                else if (free_found_reg)
                begin
                    status_next = ST_ADDED;
                    wr_en       = 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
                if (has_byte_reg)
                begin
                    unique case (rx_byte_reg)
                        BYTE_S1_LOW:  sensor_next[1] = 1'b0;
                        BYTE_S1_HIGH: sensor_next[1] = 1'b1;
                        BYTE_S2_LOW:  sensor_next[2] = 1'b0;
                        BYTE_S2_HIGH: sensor_next[2] = 1'b1;
                        default:      sensor_next    = sensor_reg;
                    endcase
                end
                issue_next = '0;
                state_next = S_WSCAN;
            end
            S_WSCAN:
            begin
                if (issue_reg < SLOTS_CNT)
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                if (rd_st.vld)
                begin
                    if (mt.fire)
                    begin
                        wake_next = wake_reg | (WAKE_W'(1) << rd_data.signal);
                        clr_en    = 1'b1;
                    end
                    if (rd_idx == LAST_IDX)
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {7'd0, sensor_reg, wake_reg, added, status_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_reg      <= '0;
            req_ok_reg     <= 1'b0;
            has_byte_reg   <= 1'b0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            status_reg     <= ST_NONE;
            sensor_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            req_ok_reg     <= req_ok_next;
            has_byte_reg   <= has_byte_next;
            dup_reg        <= dup_next;
            free_found_reg <= free_found_next;
            status_reg     <= status_next;
            sensor_reg     <= sensor_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rx_byte_reg  <= rx_byte_next;
        free_idx_reg <= free_idx_next;
        wake_reg     <= wake_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_rd_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_st.vld |-> (state_reg == S_DSCAN || state_reg == S_WSCAN))
        else $error("slot read outside a scan");

    a_tick_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted tick left the sequencer idle");

    a_wake_bit0_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[5])
        else $error("wake mask bit zero set");

    a_no_write_and_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en && !clr_en)
        else $error("slot write collides with a scan");

    a_added_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && req_ok_reg && !dup_reg) |-> (wr_en == free_found_reg))
        else $error("add decision disagrees with free slot search");

endmodule

`default_nettype wire

### tb/sv/event_subscription_table_checker.sv
module event_subscription_table_checker #(
    parameter int SLOTS   = esub_pkg::DEF_SLOTS,
    parameter int SENSORS = esub_pkg::DEF_SENSORS,
    parameter int SIGNALS = esub_pkg::DEF_SIGNALS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    // request_signal[2:0], request_sensor[4:3], request_level[5], rx_byte[13:6]
    input  wire logic [esub_pkg::S_DATA_W-1:0] s_tdata,
    // has_request[0], has_byte[1]
    input  wire logic [esub_pkg::S_USER_W-1:0] s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // request_status[1:0], added_slot[4:2], wake_mask[12:5], sensor_bits[16:13]
    input  wire logic [esub_pkg::M_DATA_W-1:0] m_tdata,
    output int                                 mismatch_count,
    output int                                 results_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import esub_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [ADDED_W-1:0]  slot;
        logic [WAKE_W-1:0]   wake;
        logic [BITS_W-1:0]   levels;
    } tick_result_t;

    // shadow copy of the subscription table and the sensor levels
    logic [SIG_W-1:0] entry_signal [SLOTS];
    logic [SEN_W-1:0] entry_sensor [SLOTS];
    logic             entry_level  [SLOTS];
    logic             sensor_now   [SENSORS];

    tick_result_t pending_results [$];
    tick_result_t want;
    tick_result_t got;

    function automatic tick_result_t tick_outcome(
        input logic             req,
        input logic [SIG_W-1:0] sig,
        input logic [SEN_W-1:0] sen,
        input logic             lvl,
        input logic             hb,
        input logic [7:0]       rx
    );
        tick_result_t r;
        bit           dup;
        int           free_idx;
        logic         cur;
        r.status = ST_NONE;
        r.slot   = '0;
        r.wake   = '0;
        r.levels = '0;
        if (req && sig != 0 && sig < SIGNALS && sen < SENSORS)
        begin
            dup = 1'b0;
            for (int i = 0; i < SLOTS; i++)
                if (entry_signal[i] != 0 && entry_signal[i] == sig &&
                    entry_sensor[i] == sen && entry_level[i] == lvl)
                    dup = 1'b1;
            if (dup)
                r.status = ST_DUP;
            else
            begin
                free_idx = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (entry_signal[i] == 0)
                        free_idx = i;
                if (free_idx < 0)
                    r.status = ST_FULL;
                else
                begin
                    entry_signal[free_idx] = sig;
                    entry_sensor[free_idx] = sen;
                    entry_level[free_idx]  = lvl;
                    r.status = ST_ADDED;
                    r.slot   = ADDED_W'(free_idx);
                end
            end
        end
        if (hb)
        begin
            case (rx)
                BYTE_S1_LOW:  sensor_now[1] = 1'b0;
                BYTE_S1_HIGH: sensor_now[1] = 1'b1;
                BYTE_S2_LOW:  sensor_now[2] = 1'b0;
                BYTE_S2_HIGH: sensor_now[2] = 1'b1;
                default: ;
            endcase
        end
        // a slot stored above is scanned too, so it may fire in the same tick
        for (int i = 0; i < SLOTS; i++)
        begin
            if (entry_signal[i] != 0)
            begin
                cur = (entry_sensor[i] < SENSORS) ? sensor_now[entry_sensor[i]] : 1'b0;
                if (cur != entry_level[i])
                begin
                    r.wake[entry_signal[i]] = 1'b1;
                    entry_signal[i] = '0;
                    entry_sensor[i] = '0;
                    entry_level[i]  = 1'b0;
                end
            end
        end
        for (int i = 0; i < BITS_W && i < SENSORS; i++)
            r.levels[i] = sensor_now[i];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns  result mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    initial
    begin
        mismatch_count = 0;
        results_due    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                entry_signal[i] = '0;
                entry_sensor[i] = '0;
                entry_level[i]  = 1'b0;
            end
            for (int i = 0; i < SENSORS; i++)
                sensor_now[i] = 1'b0;
            pending_results.delete();
            results_due = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pending_results.push_back(tick_outcome(s_tuser[0], s_tdata[2:0],
                    s_tdata[4:3], s_tdata[5], s_tuser[1], s_tdata[13:6]));
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tdata[1:0]);
                got.slot   = m_tdata[4:2];
                got.wake   = m_tdata[12:5];
                got.levels = m_tdata[16:13];
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result %h with nothing outstanding", m_tdata));
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("request_status %s, want %s",
                            got.status.name(), want.status.name()));
                    if (got.slot != want.slot)
                        report_mismatch($sformatf("added_slot %0d, want %0d",
                            got.slot, want.slot));
                    if (got.wake != want.wake)
                        report_mismatch($sformatf("wake_mask %b, want %b",
                            got.wake, want.wake));
                    if (got.levels != want.levels)
                        report_mismatch($sformatf("sensor_bits %b, want %b",
                            got.levels, want.levels));
                end
            end
            results_due = pending_results.size();
        end
    end

endmodule

### tb/sv/event_subscription_table_tb.sv
module event_subscription_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import esub_pkg::*;

    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 2 * DEF_SLOTS + 12;

    // entries on sensors 0 and 3 with level 0 never fire, so only these two are made
    localparam logic [SIG_W-1:0] STUCK_A_SIG = 3'd1;
    localparam logic [SEN_W-1:0] STUCK_A_SEN = 2'd0;
    localparam logic [SIG_W-1:0] STUCK_B_SIG = 3'd5;
    localparam logic [SEN_W-1:0] STUCK_B_SEN = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [S_USER_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    int mismatch_count;
    int results_due;
    int send_idle_pct = 25;
    int recv_idle_pct = 25;
    bit hold_start = 1'b0;

    event_subscription_table u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    event_subscription_table_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always #5 clk = ~clk;

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES - 1;
                m_tready   = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready = 1'b0;
            end
            else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                stall_left = $urandom_range(0, 4);
                m_tready   = 1'b0;
            end
            else
                m_tready = 1'b1;
        end
    end

    task automatic send_tick(
        input logic             req,
        input logic [SIG_W-1:0] sig,
        input logic [SEN_W-1:0] sen,
        input logic             lvl,
        input logic             hb,
        input logic [7:0]       rx
    );
        int gap;
        gap = 0;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 5);
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            s_tdata  = S_DATA_W'($urandom);
            s_tuser  = S_USER_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, rx, lvl, sen, sig};
        s_tuser  = {hb, req};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (results_due != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] sensor_byte();
        case ($urandom_range(0, 3))
            0:       return BYTE_S1_LOW;
            1:       return BYTE_S1_HIGH;
            2:       return BYTE_S2_LOW;
            default: return BYTE_S2_HIGH;
        endcase
    endfunction

    // mostly churn on sensors 1 and 2, with some noise and corner requests
    task automatic random_tick();
        logic [SIG_W-1:0] sig;
        logic [SEN_W-1:0] sen;
        logic             lvl;
        logic             req;
        logic             hb;
        logic [7:0]       rx;
        int               pick;
        sig  = SIG_W'($urandom_range(1, 7));
        sen  = SEN_W'($urandom_range(1, 2));
        lvl  = 1'($urandom_range(0, 1));
        req  = $urandom_range(0, 99) < 70;
        hb   = $urandom_range(0, 99) < 60;
        rx   = sensor_byte();
        pick = $urandom_range(0, 99);
        if (pick < 10)
            rx = 8'($urandom_range(0, 255));
        else if (pick < 16)
        begin
            sen = $urandom_range(0, 1) ? STUCK_B_SEN : STUCK_A_SEN;
            lvl = 1'b1;
        end
        else if (pick < 20)
            sig = '0;
        else if (pick < 24)
        begin
            lvl = 1'b0;
            if ($urandom_range(0, 1))
            begin
                sig = STUCK_A_SIG;
                sen = STUCK_A_SEN;
            end
            else
            begin
                sig = STUCK_B_SIG;
                sen = STUCK_B_SEN;
            end
        end
        send_tick(req, sig, sen, lvl, hb, rx);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill slots 0..5 on sensors 1 and 2, then the two permanent entries
        send_tick(1'b1, 3'd1, 2'd1, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 3'd1, 2'd1, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 3'd2, 2'd2, 1'b0, 1'b1, 8'h65);
        send_tick(1'b1, 3'd3, 2'd1, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 3'd7, 2'd2, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 3'd4, 2'd1, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 3'd6, 2'd2, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, STUCK_A_SIG, STUCK_A_SEN, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, STUCK_B_SIG, STUCK_B_SEN, 1'b0, 1'b0, 8'h00);
        // table full, then a signal zero request and a byte without its flag
        send_tick(1'b1, 3'd2, 2'd1, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 3'd0, 2'd1, 1'b1, 1'b0, BYTE_S1_HIGH);
        send_tick(1'b0, 3'd0, 2'd0, 1'b0, 1'b1, BYTE_S1_HIGH);
        send_tick(1'b1, 3'd7, 2'd2, 1'b1, 1'b1, BYTE_S2_HIGH);
        // new slots that fire in the tick they are stored
        send_tick(1'b1, 3'd3, 2'd1, 1'b1, 1'b1, BYTE_S1_LOW);
        send_tick(1'b1, 3'd6, 2'd0, 1'b1, 1'b0, 8'h00);
        send_tick(1'b1, 3'd4, 2'd3, 1'b1, 1'b1, BYTE_S2_LOW);
        send_tick(1'b1, STUCK_A_SIG, STUCK_A_SEN, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, STUCK_B_SIG, STUCK_B_SEN, 1'b0, 1'b1, 8'hff);
        send_tick(1'b0, 3'd7, 2'd3, 1'b1, 1'b1, 8'h00);
        send_tick(1'b1, 3'd7, 2'd2, 1'b1, 1'b1, BYTE_S1_HIGH);
        send_tick(1'b1, 3'd2, 2'd1, 1'b1, 1'b1, BYTE_S2_HIGH);
        send_tick(1'b0, 3'd0, 2'd0, 1'b0, 1'b0, 8'h80);
        wait_drained();

        send_idle_pct = 30;
        recv_idle_pct = 30;
        repeat (400) random_tick();

        // long result back-pressure while ticks keep coming
        hold_start = 1'b1;
        repeat (30) random_tick();

        send_idle_pct = 15;
        recv_idle_pct = 15;
        repeat (400) random_tick();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (400) random_tick();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #(4_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
hdl/esub_pkg.sv
hdl/esub_slot_mem.sv
hdl/esub_match.sv
hdl/event_subscription_table.sv
tb/sv/event_subscription_table_checker.sv
tb/sv/event_subscription_table_tb.sv
